>>> rtl/core/sda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment direction angle package
// Shared widths, request and result types and the arctangent table used by
// the segment direction angle pipeline.
// ----------------------------------------------------------------------------
package sda_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_STAGES = 16;
  localparam int TABLE_LEN    = 24;
  localparam int ROT_STAGES   = (ANGLE_STAGES < TABLE_LEN) ? ANGLE_STAGES : TABLE_LEN;

  localparam int DIFF_W    = COORD_WIDTH + 1;
  localparam int MAG_W     = DIFF_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int NORM_TOP  = 40;
  localparam int NORM_W    = NORM_TOP + 1;
  localparam int PRE_SHIFT = NORM_TOP - COORD_WIDTH;
  localparam int ROT_W     = NORM_W + 3;
  localparam int ZW        = 22;
  localparam int LEN_W     = 50;
  localparam int ANGLE_W   = 18;
  localparam int THETA_W   = 16;

  localparam logic OP_DIRECTION = 1'b0;
  localparam logic OP_SLOPE     = 1'b1;

  localparam logic [THETA_W-1:0]        HALF_PI  = 16'd32768;
  localparam logic signed [ANGLE_W-1:0] PI_UNITS = 18'sd65536;

  localparam logic [ZW-1:0] ATAN_UNITS [TABLE_LEN] = '{
    22'd262144, 22'd154753, 22'd81767, 22'd41506, 22'd20834, 22'd10427,
    22'd5215,   22'd2608,   22'd1304,  22'd652,   22'd326,   22'd163,
    22'd81,     22'd41,     22'd20,    22'd10,    22'd5,     22'd3,
    22'd1,      22'd1,      22'd0,     22'd0,     22'd0,     22'd0
  };

  typedef struct packed {
    logic                          opcode;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
  } in_req_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [LEN_W-1:0]          length_squared;
    logic                      degenerate;
  } out_res_t;

  typedef struct packed {
    logic opcode;
    logic dx_neg;
    logic dy_neg;
    logic x_zero;
    logic y_zero;
  } flags_t;

  typedef struct packed {
    flags_t           flags;
    logic [LEN_W-1:0] length;
  } side_t;

endpackage

>>> rtl/core/sda_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment front end
// Forms the difference vector, its magnitudes and squared length, and
// normalises the magnitudes over two stages for the rotation pipeline.
// ----------------------------------------------------------------------------
module sda_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  sda_pkg::in_req_t            up_req,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output sda_pkg::side_t              dn_side,
  output logic [sda_pkg::NORM_W-1:0]  dn_x,
  output logic [sda_pkg::NORM_W-1:0]  dn_y
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic                               op1_r;
  logic signed [sda_pkg::DIFF_W-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;

  sda_pkg::flags_t                    fl2_r, fl2_nxt;
  logic [sda_pkg::MAG_W-1:0]          ax_r, ay_r, ax_nxt, ay_nxt;

  sda_pkg::flags_t                    fl3_r;
  logic [sda_pkg::SQ_W-1:0]           sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic [sda_pkg::NORM_W-1:0]         nx3_r, ny3_r, nm3_r, nx3_nxt, ny3_nxt, nm3_nxt;

  sda_pkg::side_t                     side4_r, side4_nxt;
  logic [sda_pkg::NORM_W-1:0]         nx4_r, ny4_r, nx4_nxt, ny4_nxt;

  assign rdy4     = !v4_r || dn_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  assign dn_valid = v4_r;
  assign dn_side  = side4_r;
  assign dn_x     = nx4_r;
  assign dn_y     = ny4_r;

  assign dx_nxt = sda_pkg::DIFF_W'(up_req.end_x) - sda_pkg::DIFF_W'(up_req.start_x);
  assign dy_nxt = sda_pkg::DIFF_W'(up_req.end_y) - sda_pkg::DIFF_W'(up_req.start_y);

  always_comb begin
    ax_nxt         = sda_pkg::MAG_W'(unsigned'(dx_r[sda_pkg::DIFF_W-1] ? -dx_r : dx_r));
    ay_nxt         = sda_pkg::MAG_W'(unsigned'(dy_r[sda_pkg::DIFF_W-1] ? -dy_r : dy_r));
    fl2_nxt.opcode = op1_r;
    fl2_nxt.dx_neg = dx_r[sda_pkg::DIFF_W-1];
    fl2_nxt.dy_neg = dy_r[sda_pkg::DIFF_W-1];
    fl2_nxt.x_zero = (dx_r == '0);
    fl2_nxt.y_zero = (dy_r == '0);
  end

  always_comb begin
    sqx_nxt = ax_r * ax_r;
    sqy_nxt = ay_r * ay_r;
    nm3_nxt = sda_pkg::NORM_W'((ax_r > ay_r) ? ax_r : ay_r) << sda_pkg::PRE_SHIFT;
    nx3_nxt = sda_pkg::NORM_W'(ax_r) << sda_pkg::PRE_SHIFT;
    ny3_nxt = sda_pkg::NORM_W'(ay_r) << sda_pkg::PRE_SHIFT;
    if (nm3_nxt[sda_pkg::NORM_TOP -: 32] == '0) begin
      nm3_nxt = nm3_nxt << 32;
      nx3_nxt = nx3_nxt << 32;
      ny3_nxt = ny3_nxt << 32;
    end
    if (nm3_nxt[sda_pkg::NORM_TOP -: 16] == '0) begin
      nm3_nxt = nm3_nxt << 16;
      nx3_nxt = nx3_nxt << 16;
      ny3_nxt = ny3_nxt << 16;
    end
    if (nm3_nxt[sda_pkg::NORM_TOP -: 8] == '0) begin
      nm3_nxt = nm3_nxt << 8;
      nx3_nxt = nx3_nxt << 8;
      ny3_nxt = ny3_nxt << 8;
    end
  end

  always_comb begin
    logic [sda_pkg::SQ_W:0]   sum;
    logic [sda_pkg::NORM_W-1:0] nm;
    sum                = {1'b0, sqx_r} + {1'b0, sqy_r};
    side4_nxt.flags    = fl3_r;
    side4_nxt.length   = sda_pkg::LEN_W'(sum);
    nm                 = nm3_r;
    nx4_nxt            = nx3_r;
    ny4_nxt            = ny3_r;
    if (nm[sda_pkg::NORM_TOP -: 4] == '0) begin
      nm      = nm << 4;
      nx4_nxt = nx4_nxt << 4;
      ny4_nxt = ny4_nxt << 4;
    end
    if (nm[sda_pkg::NORM_TOP -: 2] == '0) begin
      nm      = nm << 2;
      nx4_nxt = nx4_nxt << 2;
      ny4_nxt = ny4_nxt << 2;
    end
    if (!nm[sda_pkg::NORM_TOP]) begin
      nx4_nxt = nx4_nxt << 1;
      ny4_nxt = ny4_nxt << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r <= up_req.opcode;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
    end
    if (rdy2) begin
      fl2_r <= fl2_nxt;
      ax_r  <= ax_nxt;
      ay_r  <= ay_nxt;
    end
    if (rdy3) begin
      fl3_r <= fl2_r;
      sqx_r <= sqx_nxt;
      sqy_r <= sqy_nxt;
      nm3_r <= nm3_nxt;
      nx3_r <= nx3_nxt;
      ny3_r <= ny3_nxt;
    end
    if (rdy4) begin
      side4_r <= side4_nxt;
      nx4_r   <= nx4_nxt;
      ny4_r   <= ny4_nxt;
    end
  end

endmodule

>>> rtl/core/sda_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring rotation pipeline
// One registered rotation per stage, driving y towards zero and summing the
// arctangent table into the angle accumulator.
// ----------------------------------------------------------------------------
module sda_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             up_valid,
  output logic                             up_ready,
  input  sda_pkg::side_t                   up_side,
  input  logic [sda_pkg::NORM_W-1:0]       up_x,
  input  logic [sda_pkg::NORM_W-1:0]       up_y,
  output logic                             dn_valid,
  input  logic                             dn_ready,
  output sda_pkg::side_t                   dn_side,
  output logic signed [sda_pkg::ZW-1:0]    dn_z
);

  wire                                rdy     [sda_pkg::ROT_STAGES+1];
  wire                                vld_in  [sda_pkg::ROT_STAGES+1];
  wire signed [sda_pkg::ROT_W-1:0]    x_in    [sda_pkg::ROT_STAGES+1];
  wire signed [sda_pkg::ROT_W-1:0]    y_in    [sda_pkg::ROT_STAGES+1];
  wire signed [sda_pkg::ZW-1:0]       z_in    [sda_pkg::ROT_STAGES+1];
  wire sda_pkg::side_t                side_in [sda_pkg::ROT_STAGES+1];

  assign vld_in[0]  = up_valid;
  assign x_in[0]    = signed'(sda_pkg::ROT_W'(up_x));
  assign y_in[0]    = signed'(sda_pkg::ROT_W'(up_y));
  assign z_in[0]    = '0;
  assign side_in[0] = up_side;
  assign up_ready   = rdy[0];

  assign rdy[sda_pkg::ROT_STAGES] = dn_ready;
  assign dn_valid = vld_in[sda_pkg::ROT_STAGES];
  assign dn_side  = side_in[sda_pkg::ROT_STAGES];
  assign dn_z     = z_in[sda_pkg::ROT_STAGES];

  for (genvar i = 0; i < sda_pkg::ROT_STAGES; i++) begin : g_rot
    logic                           vld_r;
    logic signed [sda_pkg::ROT_W-1:0] x_r, y_r, x_nxt, y_nxt;
    logic signed [sda_pkg::ZW-1:0]  z_r, z_nxt;
    sda_pkg::side_t                 side_r;

    always_comb begin
      if (!y_in[i][sda_pkg::ROT_W-1]) begin
        x_nxt = x_in[i] + (y_in[i] >>> i);
        y_nxt = y_in[i] - (x_in[i] >>> i);
        z_nxt = z_in[i] + signed'(sda_pkg::ATAN_UNITS[i]);
      end else begin
        x_nxt = x_in[i] - (y_in[i] >>> i);
        y_nxt = y_in[i] + (x_in[i] >>> i);
        z_nxt = z_in[i] - signed'(sda_pkg::ATAN_UNITS[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else if (rdy[i]) begin
        vld_r <= vld_in[i];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        x_r    <= x_nxt;
        y_r    <= y_nxt;
        z_r    <= z_nxt;
        side_r <= side_in[i];
      end
    end

    assign rdy[i]       = !vld_r || rdy[i+1];
    assign vld_in[i+1]  = vld_r;
    assign x_in[i+1]    = x_r;
    assign y_in[i+1]    = y_r;
    assign z_in[i+1]    = z_r;
    assign side_in[i+1] = side_r;
  end

endmodule

>>> rtl/core/segment_direction_angle_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment direction angle
// An accepted request passes four front-end stages, sixteen rotation stages,
// the rounding register and the output register on its way to the result.
// Throughput: one request per cycle; each stage holds only while the stage
// after it is full and stalled. Reset empties every stage at once.
// ----------------------------------------------------------------------------
module segment_direction_angle_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sda_pkg::in_req_t    in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output sda_pkg::out_res_t   out_res
);

  logic                           fe_valid, fe_ready;
  sda_pkg::side_t                 fe_side;
  logic [sda_pkg::NORM_W-1:0]     fe_x, fe_y;
  logic                           up_ready;

  logic                           cr_valid, cr_ready;
  sda_pkg::side_t                 cr_side;
  logic signed [sda_pkg::ZW-1:0]  cr_z;

  logic                           th_vld_r, th_ready;
  sda_pkg::side_t                 th_side_r;
  logic [sda_pkg::THETA_W-1:0]    theta_r, theta_nxt;

  logic                           out_valid_r, out_ready;
  sda_pkg::out_res_t              out_res_r, out_res_nxt;

  sda_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (up_ready),
    .up_req   (in_req),
    .dn_valid (fe_valid),
    .dn_ready (fe_ready),
    .dn_side  (fe_side),
    .dn_x     (fe_x),
    .dn_y     (fe_y)
  );

  sda_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fe_valid),
    .up_ready (fe_ready),
    .up_side  (fe_side),
    .up_x     (fe_x),
    .up_y     (fe_y),
    .dn_valid (cr_valid),
    .dn_ready (cr_ready),
    .dn_side  (cr_side),
    .dn_z     (cr_z)
  );

  assign in_stall  = !up_ready;
  assign out_ready = !out_valid_r || !out_stall;
  assign th_ready  = !th_vld_r || out_ready;
  assign cr_ready  = th_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    logic signed [sda_pkg::ZW-1:0] zr;
    zr = (cr_z + sda_pkg::ZW'(8)) >>> 4;
    if (cr_side.flags.y_zero) begin
      theta_nxt = '0;
    end else if (cr_side.flags.x_zero) begin
      theta_nxt = sda_pkg::HALF_PI;
    end else if (zr < 0) begin
      theta_nxt = '0;
    end else if (zr > signed'(sda_pkg::ZW'(sda_pkg::HALF_PI))) begin
      theta_nxt = sda_pkg::HALF_PI;
    end else begin
      theta_nxt = sda_pkg::THETA_W'(zr);
    end
  end

  always_comb begin
    logic signed [sda_pkg::ANGLE_W-1:0] a_pos, a_flip, a;
    sda_pkg::flags_t                    fl;
    fl     = th_side_r.flags;
    a_pos  = signed'(sda_pkg::ANGLE_W'(theta_r));
    a_flip = sda_pkg::PI_UNITS - a_pos;
    if (fl.opcode == sda_pkg::OP_DIRECTION) begin
      a = fl.dx_neg ? a_flip : a_pos;
      if (fl.dy_neg) a = -a;
    end else begin
      a = (fl.dx_neg == fl.dy_neg) ? a_pos : a_flip;
    end
    out_res_nxt.degenerate     = fl.x_zero && fl.y_zero;
    out_res_nxt.angle          = out_res_nxt.degenerate ? '0 : a;
    out_res_nxt.length_squared = th_side_r.length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      th_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (th_ready)  th_vld_r    <= cr_valid;
      if (out_ready) out_valid_r <= th_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (th_ready) begin
      th_side_r <= cr_side;
      theta_r   <= theta_nxt;
    end
    if (out_ready) begin
      out_res_r <= out_res_nxt;
    end
  end

endmodule
